// ----- rtl/core/mpd_pkg.sv -----
// Shared types and constants for the mouse packet decoder and tracker.
`default_nettype none
package mpd_pkg;

  localparam int POSITION_BITS = 12;
  localparam int LIMIT_BITS    = 12;
  localparam int OUT_POS_BITS  = 12;
  localparam int OUT_TDATA_W   = 48;

  localparam logic [2:0]            BUTTON_MASK    = 3'h7;
  localparam logic [LIMIT_BITS-1:0] RESET_X_LIMIT  = LIMIT_BITS'(1024);
  localparam logic [LIMIT_BITS-1:0] RESET_Y_LIMIT  = LIMIT_BITS'(768);
  localparam logic [POSITION_BITS-1:0] RESET_CURSOR_X = POSITION_BITS'(512);
  localparam logic [POSITION_BITS-1:0] RESET_CURSOR_Y = POSITION_BITS'(384);

  typedef enum logic [0:0] {
    CFG_X_LIMIT = 1'b0,
    CFG_Y_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       from_mouse;
    logic [7:0] rx_byte;
  } in_item_t;

  // Declared highest field first so that move_x lands in the lowest bits.
  typedef struct packed {
    logic [OUT_POS_BITS-1:0] pos_y;
    logic [OUT_POS_BITS-1:0] pos_x;
    logic [2:0]              button_changes;
    logic [2:0]              button_bits;
    logic signed [7:0]       move_y;
    logic signed [7:0]       move_x;
  } result_t;

  // Control from the tracker: advance to the input register, fire to the result register.
  typedef struct packed {
    logic advance;
    logic fire;
  } trk_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/mpd_in_stage.sv -----
// Input register for received bytes.
`default_nettype none
module mpd_in_stage
  import mpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          s_valid,
  output in_item_t      s_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule
`default_nettype wire

// ----- rtl/core/mpd_track.sv -----
// Packet assembly, button change mask, cursor update and limit registers.
`default_nettype none
module mpd_track
  import mpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [LIMIT_BITS-1:0] cfg_wdata,
  input  wire logic                  s_valid,
  input  wire in_item_t              s_item,
  input  wire logic                  out_free,
  output trk_ctl_t                   ctl,
  output result_t                    result
);

  localparam int CW = POSITION_BITS + 2;
  localparam logic [CW-1:0] POS_TOP = CW'((1 << POSITION_BITS) - 1);

  logic [LIMIT_BITS-1:0]    x_limit_r, y_limit_r;
  logic [1:0]               count_r, count_nxt;
  logic [7:0]               first_r, second_r;
  logic [2:0]               last_btn_r;
  logic [POSITION_BITS-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;

  logic       third;
  logic       take;
  logic [7:0] ny;
  logic [2:0] buttons;

  function automatic logic [POSITION_BITS-1:0] move_axis(
    input logic [POSITION_BITS-1:0] pos,
    input logic signed [7:0]        delta,
    input logic [LIMIT_BITS-1:0]    limit
  );
    logic [CW-1:0]        lim;
    logic signed [CW-1:0] p;
    lim = (CW'(limit) < POS_TOP) ? CW'(limit) : POS_TOP;
    p   = $signed({2'b00, pos}) + CW'(delta);
    if (p < 0) begin
      p = '0;
    end else if ($unsigned(p) > lim) begin
      p = $signed(lim);
    end
    return POSITION_BITS'($unsigned(p));
  endfunction

  assign third       = s_item.from_mouse && (count_r == 2'd2);
  assign ctl.advance = s_valid && (!third || out_free);
  assign ctl.fire    = ctl.advance && third;
  assign take        = ctl.advance && s_item.from_mouse;

  assign ny      = 8'(8'd0 - s_item.rx_byte);
  assign buttons = first_r[2:0] & BUTTON_MASK;

  always_comb begin
    count_nxt = (count_r == 2'd2) ? 2'd0 : count_r + 2'd1;
    cur_x_nxt = move_axis(cur_x_r, $signed(second_r), x_limit_r);
    cur_y_nxt = move_axis(cur_y_r, $signed(ny), y_limit_r);
  end

  always_comb begin
    result.move_x         = $signed(second_r);
    result.move_y         = $signed(ny);
    result.button_bits    = buttons;
    result.button_changes = buttons ^ last_btn_r;
    result.pos_x          = OUT_POS_BITS'(cur_x_nxt);
    result.pos_y          = OUT_POS_BITS'(cur_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r  <= RESET_X_LIMIT;
      y_limit_r  <= RESET_Y_LIMIT;
      count_r    <= 2'd0;
      first_r    <= 8'd0;
      second_r   <= 8'd0;
      last_btn_r <= 3'd0;
      cur_x_r    <= RESET_CURSOR_X;
      cur_y_r    <= RESET_CURSOR_Y;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_X_LIMIT: x_limit_r <= cfg_wdata;
          CFG_Y_LIMIT: y_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        count_r <= count_nxt;
        case (count_r)
          2'd0: first_r  <= s_item.rx_byte;
          2'd1: second_r <= s_item.rx_byte;
          default: begin
            last_btn_r <= buttons;
            cur_x_r    <= cur_x_nxt;
            cur_y_r    <= cur_y_nxt;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mpd_out_stage.sv -----
// Result register towards the output stream.
`default_nettype none
module mpd_out_stage
  import mpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule
`default_nettype wire

// ----- rtl/core/mouse_packet_decoder_tracker_top.sv -----
// Top level of the mouse packet decoder and cursor tracker.
// Takes one controller byte per beat; bytes with tuser low are dropped, mouse
// bytes are gathered in threes and every third one yields a result beat with
// the X/Y deltas (Y negated), the buttons, the changed-button mask and the
// cursor position clamped to 0..x_limit / 0..y_limit. A byte is accepted every
// cycle while the result side keeps up; each byte is held in the input register,
// the result that it completes is held in the result register, and the result
// register lets the next bytes enter while a finished result waits.
`default_nettype none
module mouse_packet_decoder_tracker_top
  import mpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [LIMIT_BITS-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // rx_byte
  input  wire logic                   in_tuser,   // from_mouse
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // move_x[7:0], move_y[15:8], button_bits[18:16], button_changes[21:19],
  // pos_x[33:22], pos_y[45:34], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  in_item_t in_item, s_item;
  logic     s_valid;
  logic     out_free;
  trk_ctl_t ctl;
  result_t  result, out_result;

  assign in_item.rx_byte    = in_tdata;
  assign in_item.from_mouse = in_tuser;

  mpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (ctl.advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  mpd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_item    (s_item),
    .out_free  (out_free),
    .ctl       (ctl),
    .result    (result)
  );

  mpd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctl.fire),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_result};

endmodule
`default_nettype wire

// ----- verif/mpd_tb_pkg.sv -----
// Scoreboard for the mouse packet decoder: predicts each result beat and checks it.
package mpd_tb_pkg;
  import mpd_pkg::*;

  class packet_scoreboard;
    logic [LIMIT_BITS-1:0]    x_limit;
    logic [LIMIT_BITS-1:0]    y_limit;
    logic [1:0]               bytes_held;
    logic [7:0]               header_byte;
    logic [7:0]               x_byte;
    logic [2:0]               last_buttons;
    logic [POSITION_BITS-1:0] cursor_x;
    logic [POSITION_BITS-1:0] cursor_y;
    result_t                  expected_beats[$];
    int                       beats_checked;
    int                       errors;

    function new();
      x_limit       = RESET_X_LIMIT;
      y_limit       = RESET_Y_LIMIT;
      bytes_held    = '0;
      header_byte   = '0;
      x_byte        = '0;
      last_buttons  = '0;
      cursor_x      = RESET_CURSOR_X;
      cursor_y      = RESET_CURSOR_Y;
      beats_checked = 0;
      errors        = 0;
    endfunction

    function void write_limit(cfg_index_t idx, logic [LIMIT_BITS-1:0] value);
      case (idx)
        CFG_X_LIMIT: x_limit = value;
        CFG_Y_LIMIT: y_limit = value;
        default: ;
      endcase
    endfunction

    // Clamp to 0..limit, with the limit itself capped at the position range.
    function logic [POSITION_BITS-1:0] step_axis(logic [POSITION_BITS-1:0] pos,
                                                 logic signed [7:0] delta,
                                                 logic [LIMIT_BITS-1:0] limit);
      int top;
      int bound;
      int p;
      top   = (1 << POSITION_BITS) - 1;
      bound = (int'(limit) < top) ? int'(limit) : top;
      p     = int'(pos) + int'(delta);
      if (p < 0) p = 0;
      if (p > bound) p = bound;
      return p[POSITION_BITS-1:0];
    endfunction

    function void note_byte(logic [7:0] data, logic from_mouse);
      result_t r;
      if (!from_mouse) return;
      case (bytes_held)
        2'd0: begin
          header_byte = data;
          bytes_held  = 2'd1;
        end
        2'd1: begin
          x_byte     = data;
          bytes_held = 2'd2;
        end
        default: begin
          bytes_held       = 2'd0;
          r.move_x         = x_byte;
          // minus 128 negates to itself in eight bits
          r.move_y         = -data;
          r.button_bits    = header_byte[2:0] & BUTTON_MASK;
          r.button_changes = r.button_bits ^ last_buttons;
          last_buttons     = r.button_bits;
          cursor_x         = step_axis(cursor_x, r.move_x, x_limit);
          cursor_y         = step_axis(cursor_y, r.move_y, y_limit);
          r.pos_x          = cursor_x;
          r.pos_y          = cursor_y;
          expected_beats.push_back(r);
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] beat %0d: %s", $time, beats_checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got 'h%0h, expected 'h%0h", name, got, want));
    endtask

    task check_beat(logic [OUT_TDATA_W-1:0] tdata);
      result_t got;
      result_t want;
      got = tdata[$bits(result_t)-1:0];
      if (expected_beats.size() == 0) begin
        report($sformatf("result beat 'h%h with nothing outstanding", tdata));
        return;
      end
      want = expected_beats.pop_front();
      compare_field("move_x", 16'(got.move_x), 16'(want.move_x));
      compare_field("move_y", 16'(got.move_y), 16'(want.move_y));
      compare_field("button_bits", 16'(got.button_bits), 16'(want.button_bits));
      compare_field("button_changes", 16'(got.button_changes), 16'(want.button_changes));
      compare_field("pos_x", 16'(got.pos_x), 16'(want.pos_x));
      compare_field("pos_y", 16'(got.pos_y), 16'(want.pos_y));
      compare_field("pad", 16'(tdata[OUT_TDATA_W-1:$bits(result_t)]), 16'(0));
      beats_checked++;
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
// Testbench top: drives controller bytes and limit writes, checks every result beat.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;
  import mpd_tb_pkg::*;

  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  cfg_index_t             cfg_index  = CFG_X_LIMIT;
  logic [LIMIT_BITS-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  packet_scoreboard sb;
  int burst_left  = 0;
  int mouse_bytes = 0;
  int stall_left  = 0;
  int ready_mode  = 0;

  mouse_packet_decoder_tracker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: switch now and then between always ready, coin toss and long stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: begin
          out_tready <= ($urandom_range(0, 15) != 0);
          if ($urandom_range(0, 30) == 0) stall_left = $urandom_range(1, 20);
        end
      endcase
    end
    if ($urandom_range(0, 199) == 0) ready_mode = $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
  end

  // Send one byte; open a fresh burst after a random gap when the current one runs out.
  task automatic send_byte(input logic [7:0] data, input logic from_mouse);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= from_mouse;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(data, from_mouse);
    if (from_mouse) mouse_bytes++;
  endtask

  // Mouse byte, now and then preceded by a stray keyboard byte.
  task automatic send_mouse(input logic [7:0] data);
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(data, 1'b1);
  endtask

  function automatic logic [7:0] pick_delta(drift_t drift);
    case (drift)
      DRIFT_UP:   return 8'($urandom_range(32, 127));
      DRIFT_DOWN: return 8'(-$urandom_range(32, 128));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Y byte carries the negated delta so that both axes follow the drift.
  task automatic send_packet(input drift_t drift);
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
    int         cut;
    hdr = 8'($urandom_range(0, 255));
    dx  = pick_delta(drift);
    dy  = pick_delta(drift);
    cut = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 2) : 3;
    send_mouse(hdr);
    if (cut > 1) send_mouse(dx);
    if (cut > 2) send_mouse(-dy);
  endtask

  // Drop valid and wait until every result is out and the pipeline is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(input logic [LIMIT_BITS-1:0] x, input logic [LIMIT_BITS-1:0] y);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_LIMIT;
    cfg_wdata <= x;
    @(posedge clk);
    sb.write_limit(CFG_X_LIMIT, x);
    cfg_index <= CFG_Y_LIMIT;
    cfg_wdata <= y;
    @(posedge clk);
    sb.write_limit(CFG_Y_LIMIT, y);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_BITS-1:0] x, input logic [LIMIT_BITS-1:0] y,
                           input drift_t drift, input int bytes);
    int target;
    settle();
    set_limits(x, y);
    target = mouse_bytes + bytes;
    while (mouse_bytes < target) send_packet(drift);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored bytes, extreme deltas, minus 128 on Y, header bits set.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h07, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h0A, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hCD, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    settle();
    // Zero limits: clamp at both ends of each axis.
    set_limits('0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h03, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);

    // Random: push the cursor to the top, then lower the limits under it.
    run_phase(12'd4095, 12'd4095, DRIFT_UP, 100);
    run_phase(12'd4095, 12'd4095, DRIFT_UP, 100);
    run_phase(12'd100, 12'd50, DRIFT_NONE, 60);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), DRIFT_NONE, 100);
    run_phase(12'd4095, 12'd0, DRIFT_DOWN, 80);
    run_phase(12'd0, 12'd4095, DRIFT_UP, 80);
    run_phase(RESET_X_LIMIT, RESET_Y_LIMIT, DRIFT_NONE, 100);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), DRIFT_DOWN, 100);
    run_phase(12'($urandom_range(1, 4094)), 12'($urandom_range(1, 4094)), DRIFT_UP, 60);

    settle();
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
